>>> design/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the I2C sequencer RTL.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/i2cms_pkg.sv
// i2cms_pkg: types, codes and widths for the I2C master command sequencer.
// No dependencies.
package i2cms_pkg;

    localparam int SYS_HZ_W     = 30;
    localparam int SCL_HZ_W     = 23;
    localparam int DEN_W        = 26;
    localparam int PRESCALE_W   = 16;
    localparam int POLL_CNT_W   = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 30;

    localparam logic [SYS_HZ_W-1:0] SYS_HZ_RST = 30'd100000000;
    localparam logic [SCL_HZ_W-1:0] SCL_HZ_RST = 23'd100000;

    localparam logic [7:0] CR_STA  = 8'h80;
    localparam logic [7:0] CR_STO  = 8'h40;
    localparam logic [7:0] CR_RD   = 8'h20;
    localparam logic [7:0] CR_WR   = 8'h10;
    localparam logic [7:0] CR_NACK = 8'h08;
    localparam logic [7:0] CTR_EN  = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYS_HZ = 1'd0,
        CFG_SCL_HZ = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_HEADER = 3'd1,
        OP_SEND   = 3'd2,
        OP_RECV   = 3'd3,
        OP_POLL   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_POLL  = 2'd1,
        K_DONE  = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RI_PRE_LO = 3'd0,
        RI_PRE_HI = 3'd1,
        RI_CTRL   = 3'd2,
        RI_TX     = 3'd3,
        RI_CMD    = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_NACK    = 2'd1,
        ERR_TIMEOUT = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] slave_address;
        logic       read_not_write;
        logic       hold_bus;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       busy_req;
        logic       nack;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_index;
        logic [7:0] reg_value;
        logic [7:0] rx_data;
        logic [1:0] error_code;
        logic       last;
    } t_out;

endpackage

>>> design/i2c_master_command_sequencer.sv
// i2c_master_command_sequencer: turns init/header/send/receive/poll commands
// into register-write, poll-request, done and error beats for an I2C core.
// Depends on i2cms_pkg, i2cms_div and assert_macros.svh.
//
// One command is taken at a time; o_in_stall stays high until its last
// result beat is loaded into the output register. Header and send emit three
// result beats, receive two and a poll response one; a poll with nothing
// pending or an unused opcode emits none. Init runs the prescale division
// floor(sys/(5*scl)) through the shift-subtract divider at one quotient bit
// per cycle, then emits three beats. A stall on the output side holds the
// result beats back.
`include "assert_macros.svh"
module i2c_master_command_sequencer
    import i2cms_pkg::*;
#(
    parameter int MAX_POLLS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out
);

    localparam logic [POLL_CNT_W-1:0] MaxPolls = POLL_CNT_W'(MAX_POLLS);

    function automatic t_out mk_res(t_kind kind, t_reg_index idx, logic [7:0] val,
                                    logic [7:0] rx, t_err err, logic last);
        t_out res;
        res.kind       = kind;
        res.reg_index  = idx;
        res.reg_value  = val;
        res.rx_data    = rx;
        res.error_code = err;
        res.last       = last;
        return res;
    endfunction

    t_state                r_state, n_state;
    logic [SYS_HZ_W-1:0]   r_sys_hz;
    logic [SCL_HZ_W-1:0]   r_scl_hz;
    logic                  r_awaiting, n_awaiting;
    logic                  r_check_ack, n_check_ack;
    logic                  r_rsm, n_rsm;
    logic [POLL_CNT_W-1:0] r_poll_cnt, n_poll_cnt;
    logic [1:0]            r_idx, n_idx;
    logic [1:0]            r_num, n_num;
    logic                  r_ovalid, n_ovalid;
    t_out                  r_out;
    t_out                  r_res [3];
    t_out                  n_res [3];

    logic                  in_take;
    logic                  out_take;
    logic                  load;
    logic                  div_start;
    logic                  div_done;
    logic [SYS_HZ_W-1:0]   div_quot;
    logic [DEN_W-1:0]      div_den;
    logic [SYS_HZ_W-1:0]   quot_m1;
    logic [PRESCALE_W-1:0] prescale;
    logic [POLL_CNT_W-1:0] cnt_inc;

    assign div_den = (DEN_W'(r_scl_hz) << 2) + DEN_W'(r_scl_hz);

    i2cms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sys_hz),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        quot_m1 = div_quot - 1'b1;
        if (div_quot == '0) begin
            prescale = '0;
        end else if (|quot_m1[SYS_HZ_W-1:PRESCALE_W]) begin
            prescale = '1;
        end else begin
            prescale = quot_m1[PRESCALE_W-1:0];
        end
    end

    // handshake and unit control
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        in_take    = i_in_valid && (r_state == ST_IDLE);
        out_take   = r_ovalid && !i_out_stall;
        load       = (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall);
        div_start  = in_take && (i_in.opcode == OP_INIT);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    case (i_in.opcode)
                        OP_INIT:   n_state = ST_DIVIDE;
                        OP_HEADER: n_state = ST_EMIT;
                        OP_SEND:   n_state = ST_EMIT;
                        OP_RECV:   n_state = ST_EMIT;
                        OP_POLL:   n_state = r_awaiting ? ST_EMIT : ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && (r_idx == r_num - 2'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command decode, sequencer state and result staging
    always_comb begin
        n_awaiting  = r_awaiting;
        n_check_ack = r_check_ack;
        n_rsm       = r_rsm;
        n_poll_cnt  = r_poll_cnt;
        n_idx       = load ? r_idx + 2'd1 : r_idx;
        n_num       = r_num;
        n_ovalid    = load ? 1'b1 : (out_take ? 1'b0 : r_ovalid);
        n_res       = r_res;
        cnt_inc     = r_poll_cnt + 1'b1;
        if (in_take) begin
            n_idx = '0;
            case (i_in.opcode)
                OP_INIT: begin
                    n_awaiting  = 1'b0;
                    n_check_ack = 1'b0;
                    n_poll_cnt  = '0;
                    n_rsm       = 1'b0;
                    n_num       = 2'd3;
                    n_res[2]    = mk_res(K_WRITE, RI_CTRL, CTR_EN, '0, ERR_NONE, 1'b1);
                end
                OP_HEADER: begin
                    n_rsm       = i_in.hold_bus;
                    n_awaiting  = 1'b1;
                    n_check_ack = 1'b1;
                    n_poll_cnt  = '0;
                    n_num       = 2'd3;
                    n_res[0]    = mk_res(K_WRITE, RI_TX,
                                         {i_in.slave_address, i_in.read_not_write},
                                         '0, ERR_NONE, 1'b0);
                    n_res[1]    = mk_res(K_WRITE, RI_CMD, CR_STA | CR_WR, '0,
                                         ERR_NONE, 1'b0);
                    n_res[2]    = mk_res(K_POLL, RI_PRE_LO, '0, '0, ERR_NONE, 1'b1);
                end
                OP_SEND: begin
                    n_awaiting  = 1'b1;
                    n_check_ack = 1'b1;
                    n_poll_cnt  = '0;
                    n_num       = 2'd3;
                    n_res[0]    = mk_res(K_WRITE, RI_TX, i_in.tx_byte, '0, ERR_NONE, 1'b0);
                    n_res[1]    = mk_res(K_WRITE, RI_CMD,
                                         (i_in.last_byte && !r_rsm) ? (CR_STO | CR_WR)
                                                                    : CR_WR,
                                         '0, ERR_NONE, 1'b0);
                    n_res[2]    = mk_res(K_POLL, RI_PRE_LO, '0, '0, ERR_NONE, 1'b1);
                end
                OP_RECV: begin
                    n_awaiting  = 1'b1;
                    n_check_ack = 1'b0;
                    n_poll_cnt  = '0;
                    n_num       = 2'd2;
                    n_res[0]    = mk_res(K_WRITE, RI_CMD,
                                         i_in.last_byte ? (CR_STO | CR_RD | CR_NACK)
                                                        : CR_RD,
                                         '0, ERR_NONE, 1'b0);
                    n_res[1]    = mk_res(K_POLL, RI_PRE_LO, '0, '0, ERR_NONE, 1'b1);
                end
                OP_POLL: begin
                    n_num = 2'd1;
                    if (r_awaiting) begin
                        if (i_in.busy_req) begin
                            n_poll_cnt = cnt_inc;
                            if (cnt_inc >= MaxPolls) begin
                                n_awaiting = 1'b0;
                                n_res[0]   = mk_res(K_ERROR, RI_PRE_LO, '0, '0,
                                                    ERR_TIMEOUT, 1'b1);
                            end else begin
                                n_res[0]   = mk_res(K_POLL, RI_PRE_LO, '0, '0,
                                                    ERR_NONE, 1'b1);
                            end
                        end else begin
                            n_awaiting = 1'b0;
                            if (r_check_ack && i_in.nack) begin
                                n_res[0] = mk_res(K_ERROR, RI_PRE_LO, '0, '0,
                                                  ERR_NACK, 1'b1);
                            end else begin
                                n_res[0] = mk_res(K_DONE, RI_PRE_LO, '0,
                                                  r_check_ack ? 8'h00 : i_in.rx_byte,
                                                  ERR_NONE, 1'b1);
                            end
                        end
                    end
                end
                default: n_num = r_num;
            endcase
        end
        if (div_done) begin
            n_res[0] = mk_res(K_WRITE, RI_PRE_LO, prescale[7:0], '0, ERR_NONE, 1'b0);
            n_res[1] = mk_res(K_WRITE, RI_PRE_HI, prescale[15:8], '0, ERR_NONE, 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sys_hz    <= SYS_HZ_RST;
            r_scl_hz    <= SCL_HZ_RST;
            r_awaiting  <= 1'b0;
            r_check_ack <= 1'b0;
            r_rsm       <= 1'b0;
            r_poll_cnt  <= '0;
            r_idx       <= '0;
            r_num       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_awaiting  <= n_awaiting;
            r_check_ack <= n_check_ack;
            r_rsm       <= n_rsm;
            r_poll_cnt  <= n_poll_cnt;
            r_idx       <= n_idx;
            r_num       <= n_num;
            r_ovalid    <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYS_HZ: r_sys_hz <= i_cfg_data[SYS_HZ_W-1:0];
                    CFG_SCL_HZ: r_scl_hz <= i_cfg_data[SCL_HZ_W-1:0];
                    default:    r_sys_hz <= r_sys_hz;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load) begin
            r_out <= r_res[r_idx];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    `ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_state == ST_EMIT, r_idx < r_num)
    `ASSERT_IMP(a_div_done_in_divide, i_clk, i_rst_n, div_done, r_state == ST_DIVIDE)
    `ASSERT_IMP(a_poll_below_limit, i_clk, i_rst_n, r_awaiting, r_poll_cnt < MaxPolls)
    `ASSERT_NXT(a_last_beat_frees, i_clk, i_rst_n, load && r_res[r_idx].last,
                r_state == ST_IDLE && o_out.last)
    `ASSERT_NXT(a_init_clears_poll, i_clk, i_rst_n, div_start, !r_awaiting && !r_rsm)

endmodule

>>> design/i2cms_div.sv
// i2cms_div: restoring divider, one quotient bit per cycle, for the prescale.
// Depends on i2cms_pkg.
module i2cms_div
    import i2cms_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SYS_HZ_W-1:0] i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_done,
    output logic [SYS_HZ_W-1:0] o_quot
);

    localparam int StepW = $clog2(SYS_HZ_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [StepW-1:0]    r_cnt, n_cnt;
    logic [SYS_HZ_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {r_rem, r_quot[SYS_HZ_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_quot = {r_quot[SYS_HZ_W-2:0], fits};
            n_rem  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == StepW'(SYS_HZ_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
